// File: rtl/fpfa_pkg.sv
// ----------------------------------------------------------------------------
// fpfa_pkg
// Shared types, codes and microcode ROM for the fixed-partition fit allocator.
// ----------------------------------------------------------------------------
package fpfa_pkg;

  // Item function codes
  localparam logic [1:0] FUNC_LOAD    = 2'd0;
  localparam logic [1:0] FUNC_CLEAR   = 2'd1;
  localparam logic [1:0] FUNC_REQUEST = 2'd2;

  // Fit policy codes
  localparam logic [1:0] POL_FIRST = 2'd0;
  localparam logic [1:0] POL_BEST  = 2'd1;
  localparam logic [1:0] POL_WORST = 2'd2;

  // Configuration port
  localparam int CFG_ADDR_W = 1;
  localparam int CFG_DATA_W = 5;
  localparam logic [CFG_ADDR_W-1:0] CFG_FIT_POLICY  = 1'b0;
  localparam logic [CFG_ADDR_W-1:0] CFG_BLOCK_COUNT = 1'b1;

  typedef struct packed {
    logic [1:0]  func;
    logic [3:0]  entry_index;
    logic [15:0] size_value;
  } in_item_t;

  typedef struct packed {
    logic        granted;
    logic [3:0]  chosen_block;
    logic [15:0] chosen_size;
  } out_item_t;

  // Microprogram
  localparam int UPC_W = 3;
  typedef logic [UPC_W-1:0] upc_t;

  localparam upc_t UPC_FETCH   = 3'd0;
  localparam upc_t UPC_DISP_LD = 3'd1;
  localparam upc_t UPC_DISP_CL = 3'd2;
  localparam upc_t UPC_DISP_RQ = 3'd3;
  localparam upc_t UPC_SCAN    = 3'd4;
  localparam upc_t UPC_EMIT    = 3'd5;
  localparam upc_t UPC_LOAD    = 3'd6;
  localparam upc_t UPC_CLEAR   = 3'd7;

  typedef enum logic [2:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_INIT,
    ACT_SCAN,
    ACT_EMIT,
    ACT_LOAD,
    ACT_CLEAR
  } act_e;

  typedef enum logic [2:0] {
    COND_ALWAYS,
    COND_ACCEPT,
    COND_FUNC_LD,
    COND_FUNC_CL,
    COND_FUNC_RQ,
    COND_SCAN_MORE,
    COND_OUT_FREE
  } cond_e;

  // next step = condition ? tgt_t : tgt_f
  typedef struct packed {
    act_e  act;
    cond_e cond;
    upc_t  tgt_t;
    upc_t  tgt_f;
  } ctrl_t;

  typedef struct packed {
    logic accept;
    logic func_ld;
    logic func_cl;
    logic func_rq;
    logic scan_more;
    logic out_free;
  } flags_t;

  function automatic ctrl_t ucode_rom(upc_t pc);
    ctrl_t w;
    unique case (pc)
      UPC_FETCH:   w = '{ACT_FETCH, COND_ACCEPT,    UPC_DISP_LD, UPC_FETCH};
      UPC_DISP_LD: w = '{ACT_NONE,  COND_FUNC_LD,   UPC_LOAD,    UPC_DISP_CL};
      UPC_DISP_CL: w = '{ACT_NONE,  COND_FUNC_CL,   UPC_CLEAR,   UPC_DISP_RQ};
      UPC_DISP_RQ: w = '{ACT_INIT,  COND_FUNC_RQ,   UPC_SCAN,    UPC_FETCH};
      UPC_SCAN:    w = '{ACT_SCAN,  COND_SCAN_MORE, UPC_SCAN,    UPC_EMIT};
      UPC_EMIT:    w = '{ACT_EMIT,  COND_OUT_FREE,  UPC_FETCH,   UPC_EMIT};
      UPC_LOAD:    w = '{ACT_LOAD,  COND_ALWAYS,    UPC_FETCH,   UPC_FETCH};
      UPC_CLEAR:   w = '{ACT_CLEAR, COND_ALWAYS,    UPC_FETCH,   UPC_FETCH};
      default:     w = '{ACT_NONE,  COND_ALWAYS,    UPC_FETCH,   UPC_FETCH};
    endcase
    return w;
  endfunction

endpackage

// File: rtl/fpfa_seq.sv
// ----------------------------------------------------------------------------
// fpfa_seq
// Microcode sequencer: step counter, control ROM and conditional jumps.
// ----------------------------------------------------------------------------
module fpfa_seq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  fpfa_pkg::flags_t flags_i,
  output fpfa_pkg::ctrl_t  ctrl_o
);
  import fpfa_pkg::*;

  upc_t  upc_q, upc_d;
  ctrl_t ctrl;
  logic  cond_true;

  assign ctrl   = ucode_rom(upc_q);
  assign ctrl_o = ctrl;

  always_comb begin
    unique case (ctrl.cond)
      COND_ALWAYS:    cond_true = 1'b1;
      COND_ACCEPT:    cond_true = flags_i.accept;
      COND_FUNC_LD:   cond_true = flags_i.func_ld;
      COND_FUNC_CL:   cond_true = flags_i.func_cl;
      COND_FUNC_RQ:   cond_true = flags_i.func_rq;
      COND_SCAN_MORE: cond_true = flags_i.scan_more;
      COND_OUT_FREE:  cond_true = flags_i.out_free;
      default:        cond_true = 1'b1;
    endcase
    upc_d = cond_true ? ctrl.tgt_t : ctrl.tgt_f;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q <= UPC_FETCH;
    end else begin
      upc_q <= upc_d;
    end
  end

endmodule

// File: rtl/fixed_partition_fit_allocator.sv
// ----------------------------------------------------------------------------
// fixed_partition_fit_allocator
// Fixed-partition allocator: block size table with taken marks, first, best
// or worst fit search run by a microcoded sequencer.
// ----------------------------------------------------------------------------
//  channel | direction | handshake              | payload
//  --------+-----------+------------------------+-----------------------------
//  in      | input     | in_valid_i/in_ready_o  | in_item_i  (func, index, size)
//  out     | output    | out_valid_o/out_ready_i| out_item_o (granted, block, size)
//  cfg     | input     | cfg_we_i               | cfg_addr_i, cfg_wdata_i
//
//  Request: fetch, three dispatch steps, one scan step per block through the
//  single table read port plus one to drain, emit. Load: fetch, dispatch, load.
//  Clear: fetch, two dispatch steps, clear. Unused code: fetch and dispatch.
//  Reset clears the taken marks and config; the size table is not cleared.
//  A result waits in the output register; the sequencer holds in its emit
//  step only while an older result there is still not taken.
// ----------------------------------------------------------------------------
module fixed_partition_fit_allocator #(
  parameter int MAX_BLOCKS = 16,
  parameter int SIZE_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  fpfa_pkg::in_item_t                  in_item_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output fpfa_pkg::out_item_t                 out_item_o,
  input  logic                                cfg_we_i,
  input  logic [fpfa_pkg::CFG_ADDR_W-1:0]     cfg_addr_i,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0]     cfg_wdata_i
);
  import fpfa_pkg::*;

  localparam int CNT_W = $clog2(MAX_BLOCKS + 1);
  localparam int IDX_W = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;

  ctrl_t  ctrl;
  flags_t flags;

  logic [1:0]            fit_policy_q;
  logic [CFG_DATA_W-1:0] block_count_q;
  logic [MAX_BLOCKS-1:0] taken_q;
  logic [CNT_W-1:0]      rd_ptr_q;
  logic                  pv_q;
  logic                  found_q;
  logic                  out_valid_q;

  in_item_t              item_q;
  logic [SIZE_BITS-1:0]  rd_data_q;
  logic [IDX_W-1:0]      cmp_idx_q;
  logic [IDX_W-1:0]      best_idx_q;
  logic [SIZE_BITS-1:0]  best_size_q;
  out_item_t             out_item_q;

  logic [SIZE_BITS-1:0]  tbl_mem [MAX_BLOCKS];

  logic [CNT_W-1:0]      live_cnt;
  logic [SIZE_BITS-1:0]  req_size;
  logic [IDX_W-1:0]      ld_addr;
  logic                  load_hit;
  logic                  scan_issue;
  logic                  cand_fit;
  logic                  better;
  logic                  take;
  logic                  out_free;
  logic                  emit_fire;
  logic                  in_fire;

  fpfa_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .flags_i (flags),
    .ctrl_o  (ctrl)
  );

  // count above table depth is treated as full table
  assign live_cnt = (int'(block_count_q) > MAX_BLOCKS) ? CNT_W'(MAX_BLOCKS)
                                                      : CNT_W'(block_count_q);
  assign req_size = SIZE_BITS'(item_q.size_value);
  assign ld_addr  = IDX_W'(item_q.entry_index);
  assign load_hit = int'(item_q.entry_index) < int'(live_cnt);

  assign in_ready_o = (ctrl.act == ACT_FETCH);
  assign in_fire    = in_valid_i && in_ready_o;
  assign scan_issue = (ctrl.act == ACT_SCAN) && (rd_ptr_q < live_cnt);

  // compare stage works on the entry read in the cycle before
  assign cand_fit = pv_q && !taken_q[cmp_idx_q] && (rd_data_q >= req_size);
  assign better   = !found_q
                  || ((fit_policy_q == POL_BEST)  && (rd_data_q < best_size_q))
                  || ((fit_policy_q == POL_WORST) && (rd_data_q > best_size_q));
  assign take     = (ctrl.act == ACT_SCAN) && cand_fit && better;

  assign out_free  = !out_valid_q || out_ready_i;
  assign emit_fire = (ctrl.act == ACT_EMIT) && out_free;

  assign flags.accept    = in_fire;
  assign flags.func_ld   = (item_q.func == FUNC_LOAD);
  assign flags.func_cl   = (item_q.func == FUNC_CLEAR);
  assign flags.func_rq   = (item_q.func == FUNC_REQUEST);
  // the step after the last read compares the final entry, then emit
  assign flags.scan_more = scan_issue;
  assign flags.out_free  = out_free;

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_item_q;

  // size table: one write port, one registered read port
  always_ff @(posedge clk_i) begin
    if ((ctrl.act == ACT_LOAD) && load_hit) begin
      tbl_mem[ld_addr] <= SIZE_BITS'(item_q.size_value);
    end
    if (scan_issue) begin
      rd_data_q <= tbl_mem[rd_ptr_q[IDX_W-1:0]];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fit_policy_q  <= POL_FIRST;
      block_count_q <= '0;
      taken_q       <= '0;
      rd_ptr_q      <= '0;
      pv_q          <= 1'b0;
      found_q       <= 1'b0;
      out_valid_q   <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_FIT_POLICY:  fit_policy_q  <= cfg_wdata_i[1:0];
          CFG_BLOCK_COUNT: block_count_q <= cfg_wdata_i;
          default: ;
        endcase
      end
      if (ctrl.act == ACT_INIT) begin
        rd_ptr_q <= '0;
        pv_q     <= 1'b0;
        found_q  <= 1'b0;
      end
      if (ctrl.act == ACT_SCAN) begin
        pv_q <= scan_issue;
        if (scan_issue) begin
          rd_ptr_q <= rd_ptr_q + CNT_W'(1);
        end
        if (take) begin
          found_q <= 1'b1;
        end
      end
      if (ctrl.act == ACT_CLEAR) begin
        taken_q <= '0;
      end
      if (emit_fire && found_q) begin
        taken_q[best_idx_q] <= 1'b1;
      end
      if (emit_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      item_q <= in_item_i;
    end
    if (scan_issue) begin
      cmp_idx_q <= rd_ptr_q[IDX_W-1:0];
    end
    if (take) begin
      best_idx_q  <= cmp_idx_q;
      best_size_q <= rd_data_q;
    end
    if (emit_fire) begin
      out_item_q.granted      <= found_q;
      out_item_q.chosen_block <= found_q ? 4'(best_idx_q) : 4'd0;
      out_item_q.chosen_size  <= found_q ? 16'(best_size_q) : 16'd0;
    end
  end

`ifndef SYNTH
  a_mark_on_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit_fire && found_q) |=> taken_q[$past(best_idx_q)])
    else $error("granted block not marked taken");

  a_deny_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_item_o.granted) |->
      (out_item_o.chosen_block == 4'd0) && (out_item_o.chosen_size == 16'd0))
    else $error("denied result carries nonzero fields");

  a_scan_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl.act == ACT_SCAN) |-> (rd_ptr_q <= live_cnt))
    else $error("scan pointer past block count");

  a_pipe_in_scan: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pv_q |-> (ctrl.act == ACT_SCAN))
    else $error("compare stage busy outside scan");
`endif

endmodule

// File: tb/fit_alloc_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fit_alloc_checker
// Watches the item, result and config channels of the fit allocator. It keeps
// its own block size table, taken marks and settings, predicts the answer to
// each accepted request and compares every accepted result against it.
// ----------------------------------------------------------------------------
module fit_alloc_checker #(
  parameter int MAX_BLOCKS = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            in_valid_i,
  input  logic                            in_ready_i,
  input  fpfa_pkg::in_item_t              in_item_i,
  input  logic                            out_valid_i,
  input  logic                            out_ready_i,
  input  fpfa_pkg::out_item_t             out_item_i,
  input  logic                            cfg_we_i,
  input  logic [fpfa_pkg::CFG_ADDR_W-1:0] cfg_addr_i,
  input  logic [fpfa_pkg::CFG_DATA_W-1:0] cfg_wdata_i,
  output int                              fail_count_o,
  output int                              outstanding_o
);
  import fpfa_pkg::*;

  logic [1:0]  policy_q;
  logic [4:0]  count_q;
  logic [15:0] size_tab [MAX_BLOCKS];
  logic [MAX_BLOCKS-1:0] taken_q;
  out_item_t   grants_q [$];
  int          errors = 0;

  task automatic report_mismatch(input string msg);
    $display("%0t ns: mismatch: %s", $time, msg);
    errors++;
  endtask

  task automatic check_grant(input out_item_t got);
    out_item_t want;
    if (grants_q.size() == 0) begin
      report_mismatch($sformatf("unexpected result granted=%0b block=%0d size=%0d",
                                got.granted, got.chosen_block, got.chosen_size));
    end else begin
      want = grants_q.pop_front();
      if (got.granted !== want.granted)
        report_mismatch($sformatf("granted %0b, want %0b", got.granted, want.granted));
      if (got.chosen_block !== want.chosen_block)
        report_mismatch($sformatf("chosen_block %0d, want %0d",
                                  got.chosen_block, want.chosen_block));
      if (got.chosen_size !== want.chosen_size)
        report_mismatch($sformatf("chosen_size %0d, want %0d",
                                  got.chosen_size, want.chosen_size));
    end
  endtask

  task automatic predict_allocation(input in_item_t it);
    int        lim;
    int        j;
    int        pick;
    bit        found;
    bit        stop;
    out_item_t res;
    lim = (count_q > MAX_BLOCKS) ? MAX_BLOCKS : int'(count_q);
    case (it.func)
      FUNC_LOAD: begin
        // loads past the live count are dropped
        if (it.entry_index < lim) size_tab[it.entry_index] = it.size_value;
      end
      FUNC_CLEAR: taken_q = '0;
      FUNC_REQUEST: begin
        found = 1'b0;
        stop  = 1'b0;
        pick  = 0;
        for (j = 0; j < lim && !stop; j++) begin
          if (!taken_q[j] && size_tab[j] >= it.size_value) begin
            if (!found) begin
              found = 1'b1;
              pick  = j;
              // first fit, and the spare policy code, stop at the first hit
              stop  = (policy_q != POL_BEST && policy_q != POL_WORST);
            end else if (policy_q == POL_BEST && size_tab[j] < size_tab[pick]) begin
              pick = j;
            end else if (policy_q == POL_WORST && size_tab[j] > size_tab[pick]) begin
              pick = j;
            end
          end
        end
        res = '0;
        if (found) begin
          taken_q[pick]    = 1'b1;
          res.granted      = 1'b1;
          res.chosen_block = 4'(pick);
          res.chosen_size  = size_tab[pick];
        end
        grants_q.push_back(res);
      end
      default: ;
    endcase
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q = POL_FIRST;
      count_q  = '0;
      taken_q  = '0;
      grants_q.delete();
    end else begin
      if (cfg_we_i) begin
        case (cfg_addr_i)
          CFG_FIT_POLICY:  policy_q = cfg_wdata_i[1:0];
          CFG_BLOCK_COUNT: count_q  = cfg_wdata_i[4:0];
          default: ;
        endcase
      end
      // a result can never belong to the item taken on the same edge
      if (out_valid_i && out_ready_i) check_grant(out_item_i);
      if (in_valid_i && in_ready_i) predict_allocation(in_item_i);
    end
    fail_count_o  <= errors;
    outstanding_o <= grants_q.size();
  end

endmodule

// File: tb/tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the fixed-partition fit allocator: fills the size table, runs
// a short directed sequence, then phases of random loads, clears and requests
// under changing policy and block count, with random idling on both channels.
// ----------------------------------------------------------------------------
module tb;
  import fpfa_pkg::*;

  localparam logic [1:0] FUNC_UNUSED = 2'd3;
  localparam logic [1:0] POL_SPARE   = 2'd3;
  localparam int NUM_BLOCKS      = 16;
  localparam int PHASES          = 15;
  localparam int ITEMS_PER_PHASE = 50;
  localparam int SETTLE_CYCLES   = 30;
  localparam int HOLD_CYCLES     = 300;

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  in_valid_i;
  logic                  in_ready_o;
  in_item_t              in_item_i;
  logic                  out_valid_o;
  logic                  out_ready_i;
  out_item_t             out_item_o;
  logic                  cfg_we_i;
  logic [CFG_ADDR_W-1:0] cfg_addr_i;
  logic [CFG_DATA_W-1:0] cfg_wdata_i;
  int                    fail_count;
  int                    outstanding;
  bit                    calm;
  bit                    hold_req;

  logic [15:0] preset_sizes [NUM_BLOCKS] = '{
    16'd100, 16'd0, 16'd300, 16'd65535, 16'd50, 16'd300, 16'd1000, 16'd200,
    16'd50, 16'd40000, 16'd300, 16'd7, 16'd32768, 16'd1, 16'd500, 16'd300};
  logic [1:0] phase_pol [6] = '{POL_BEST, POL_WORST, POL_SPARE, POL_FIRST,
                                POL_BEST, POL_WORST};
  logic [4:0] phase_cnt [6] = '{5'd16, 5'd16, 5'd31, 5'd0, 5'd1, 5'd17};

  fixed_partition_fit_allocator uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_item_o  (out_item_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  fit_alloc_checker #(.MAX_BLOCKS(NUM_BLOCKS)) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_i    (in_ready_o),
    .in_item_i     (in_item_i),
    .out_valid_i   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_item_i    (out_item_o),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #3_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // result side: random stalls, a calm phase, and one long hold-off on request
  initial begin
    out_ready_i <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req) begin
        hold_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (calm) begin
        out_ready_i <= 1'b1;
      end else begin
        out_ready_i <= ($urandom_range(99) >= 14);
      end
    end
  end

  function automatic logic [15:0] pick_size();
    int r;
    r = $urandom_range(99);
    if (r < 15) return 16'($urandom);
    else if (r < 25) return 16'd0;
    else return 16'($urandom_range(20) * 100);
  endfunction

  // valid stays up between back-to-back items; it drops only for a gap
  task automatic offer(input logic [1:0] func, input logic [3:0] idx,
                       input logic [15:0] size);
    if (!calm && $urandom_range(99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_item_i  <= '{func: func, entry_index: idx, size_value: size};
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // wait for every answer, then give a trailing load or clear time to finish
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (outstanding != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_config(input logic [1:0] pol, input logic [4:0] cnt);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= CFG_FIT_POLICY;
    cfg_wdata_i <= CFG_DATA_W'(pol);
    @(posedge clk_i);
    cfg_addr_i  <= CFG_BLOCK_COUNT;
    cfg_wdata_i <= cnt;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
  endtask

  initial begin
    int          phase;
    int          counted;
    int          eff_count;
    int          r;
    logic [1:0]  pol;
    logic [4:0]  cnt;
    logic [1:0]  func;
    logic [3:0]  idx;
    logic [15:0] size;

    calm        = 1'b0;
    hold_req    = 1'b0;
    rst_ni      <= 1'b0;
    in_valid_i  <= 1'b0;
    in_item_i   <= '0;
    cfg_we_i    <= 1'b0;
    cfg_addr_i  <= '0;
    cfg_wdata_i <= '0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // block count is zero out of reset: nothing can fit
    offer(FUNC_REQUEST, 4'd0, 16'd0);
    drain();
    write_config(POL_FIRST, 5'd16);
    // every entry gets a size before any request can read it
    for (int i = 0; i < NUM_BLOCKS; i++) offer(FUNC_LOAD, 4'(i), preset_sizes[i]);
    offer(FUNC_REQUEST, 4'd0, 16'd0);
    offer(FUNC_REQUEST, 4'd15, 16'hFFFF);
    offer(FUNC_REQUEST, 4'd0, 16'hFFFF);
    offer(FUNC_REQUEST, 4'd5, 16'd300);
    offer(FUNC_UNUSED, 4'd9, 16'd1234);
    offer(FUNC_CLEAR, 4'd0, 16'd0);
    drain();

    for (phase = 0; phase < PHASES; phase++) begin
      if (phase < 6) begin
        pol = phase_pol[phase];
        cnt = phase_cnt[phase];
      end else begin
        pol = 2'($urandom_range(3));
        r   = $urandom_range(99);
        if (r < 10) cnt = 5'($urandom_range(17, 31));
        else if (r < 15) cnt = 5'd0;
        else cnt = 5'($urandom_range(1, 16));
      end
      write_config(pol, cnt);
      eff_count = (cnt > NUM_BLOCKS) ? NUM_BLOCKS : int'(cnt);
      calm = (phase == 4);
      // hold the result side while requests keep coming
      if (phase == 2) hold_req = 1'b1;
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        r    = $urandom_range(99);
        idx  = 4'($urandom_range(15));
        size = pick_size();
        if (phase == 2) r = r / 2;
        if (r < 55) func = FUNC_REQUEST;
        else if (r < 83) func = FUNC_LOAD;
        else if (r < 95) func = FUNC_CLEAR;
        else func = FUNC_UNUSED;
        if (func == FUNC_REQUEST || func == FUNC_CLEAR ||
            (func == FUNC_LOAD && idx < eff_count))
          counted++;
        offer(func, idx, size);
        if ($urandom_range(99) < 2) drain();
      end
      drain();
    end
    calm = 1'b0;

    if (fail_count == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
